// ----- rtl/core/pps_pkg.sv -----
package pps_pkg;

  localparam int unsigned FreqW  = 24;
  localparam int unsigned PctW   = 8;
  localparam int unsigned CodeW  = 2;
  localparam int unsigned ScaleW = 5;
  localparam int unsigned CountW = 11;

  localparam logic [FreqW-1:0]  ClockReset  = 24'd4000000;
  localparam logic [FreqW-1:0]  RatioLimit  = 24'd65504;
  localparam logic [CountW-1:0] FallbackQ   = 11'd2047;
  localparam logic [ScaleW-1:0] LastDivIdx  = 5'd31;
  localparam logic [5:0]        BestRemInit = 6'd32;
  localparam logic [6:0]        PctFull     = 7'd100;
  localparam logic [6:0]        PctDefault  = 7'd50;
  localparam logic [CodeW-1:0]  CodeMax     = 2'd3;

  localparam int unsigned DivSteps = FreqW;
  localparam int unsigned MulSteps = 7;
  localparam int unsigned ProdW    = 18;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_SHIFT = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_PDIV  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

endpackage

// ----- rtl/core/pps_if.sv -----
interface pps_req_if;
  import pps_pkg::*;

  logic              valid;
  logic              ready;
  logic [FreqW-1:0]  target_hz;
  logic [PctW-1:0]   duty_percent;

  modport source (output valid, output target_hz, output duty_percent, input ready);
  modport sink   (input valid, input target_hz, input duty_percent, output ready);
endinterface

interface pps_rsp_if;
  import pps_pkg::*;

  logic              valid;
  logic              ready;
  logic [CodeW-1:0]  prescale_code;
  logic [ScaleW-1:0] scale_value;
  logic [CountW-1:0] period_count;
  logic [CountW-1:0] duty_count;

  modport source (output valid, output prescale_code, output scale_value,
                  output period_count, output duty_count, input ready);
  modport sink   (input valid, input prescale_code, input scale_value,
                  input period_count, input duty_count, output ready);
endinterface

// ----- rtl/core/pwm_parameter_solver_core.sv -----
// Steps from request acceptance to result valid: ratio division, prescale
// shifts, a scan over divisors 1 to 32, a duty multiply, the duty division
// and the move to the output register. A new request is taken once the
// result is moved to the output register. All divisions share one radix-2
// restoring divider, one quotient bit per cycle. Synchronous active-high reset:
// idle, output empty, clock_hz back to 4000000.
module pwm_parameter_solver_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [pps_pkg::FreqW-1:0] cfg_wr_data,
  pps_req_if.sink                  req,
  pps_rsp_if.source                rsp
);
  import pps_pkg::*;

  state_t            state;
  logic [FreqW-1:0]  clock_hz;

  // shared restoring divider
  logic [FreqW-1:0]  dividend;
  logic [FreqW-1:0]  divisor;
  logic [FreqW-1:0]  rem;
  logic [FreqW-1:0]  quot;
  logic [4:0]        cnt;

  logic [FreqW-1:0]  ratio;
  logic [CodeW-1:0]  code;
  logic [ScaleW-1:0] d_idx;
  logic [5:0]        best_rem;
  logic              kept;
  logic [CountW-1:0] quot_sel;
  logic [ScaleW-1:0] div_sel;
  logic [6:0]        pct;
  logic [ProdW-1:0]  prod;
  logic [ProdW-1:0]  mcand;
  logic [CountW-1:0] duty;

  logic [FreqW:0]    rs;
  logic [FreqW+1:0]  diff;
  logic              ge;
  logic [FreqW-1:0]  rem_step;
  logic [FreqW-1:0]  quot_step;
  logic              div_last;
  logic              keep_now;
  logic [FreqW-1:0]  tgt;
  logic              out_free;

  always_comb begin
    rs        = {rem, dividend[FreqW-1]};
    diff      = {1'b0, rs} - {2'b00, divisor};
    ge        = !diff[FreqW+1];
    rem_step  = ge ? diff[FreqW-1:0] : rs[FreqW-1:0];
    quot_step = {quot[FreqW-2:0], ge};
    div_last  = (cnt == 5'(DivSteps - 1));
    keep_now  = quot_step[0] && (quot_step[FreqW-1:CountW] == '0) &&
                (rem_step[5:0] < best_rem);
    tgt       = (req.target_hz == '0) ? {4'b0000, clock_hz[FreqW-1:4]} : req.target_hz;
    out_free  = !rsp.valid || rsp.ready;
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= ClockReset;
    end else if (cfg_wr_en) begin
      clock_hz <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            dividend <= clock_hz;
            divisor  <= tgt;
            rem      <= '0;
            quot     <= '0;
            cnt      <= '0;
            pct      <= (req.duty_percent > {1'b0, PctFull}) ? PctDefault
                                                              : req.duty_percent[6:0];
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          dividend <= {dividend[FreqW-2:0], 1'b0};
          rem      <= rem_step;
          quot     <= quot_step;
          cnt      <= cnt + 5'd1;
          if (div_last) begin
            ratio <= {quot_step[FreqW-2:0], 1'b0};
            code  <= '0;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (ratio > RatioLimit && code != CodeMax) begin
            ratio <= {2'b00, ratio[FreqW-1:2]};
            code  <= code + 2'd1;
          end else begin
            dividend <= ratio;
            divisor  <= FreqW'(1);
            rem      <= '0;
            quot     <= '0;
            cnt      <= '0;
            d_idx    <= '0;
            best_rem <= BestRemInit;
            kept     <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          dividend <= {dividend[FreqW-2:0], 1'b0};
          rem      <= rem_step;
          quot     <= quot_step;
          cnt      <= cnt + 5'd1;
          if (div_last) begin
            if (keep_now) begin
              best_rem <= rem_step[5:0];
              quot_sel <= quot_step[CountW-1:0];
              div_sel  <= d_idx;
              kept     <= 1'b1;
            end
            if (d_idx == LastDivIdx) begin
              // no divisor kept: fall back to 2047 over 32
              if (!keep_now && !kept) begin
                quot_sel <= FallbackQ;
                div_sel  <= LastDivIdx;
                mcand    <= ProdW'(FallbackQ);
              end else if (keep_now) begin
                mcand    <= ProdW'(quot_step[CountW-1:0]);
              end else begin
                mcand    <= ProdW'(quot_sel);
              end
              prod  <= '0;
              cnt   <= '0;
              state <= S_MUL;
            end else begin
              d_idx    <= d_idx + 5'd1;
              dividend <= ratio;
              divisor  <= FreqW'(d_idx) + FreqW'(2);
              rem      <= '0;
              quot     <= '0;
              cnt      <= '0;
            end
          end
        end
        S_MUL: begin
          if (pct[0]) begin
            prod <= prod + mcand;
          end
          mcand <= {mcand[ProdW-2:0], 1'b0};
          pct   <= {1'b0, pct[6:1]};
          cnt   <= cnt + 5'd1;
          if (cnt == 5'(MulSteps - 1)) begin
            dividend <= FreqW'(pct[0] ? prod + mcand : prod);
            divisor  <= FreqW'(PctFull);
            rem      <= '0;
            quot     <= '0;
            cnt      <= '0;
            state    <= S_PDIV;
          end
        end
        S_PDIV: begin
          dividend <= {dividend[FreqW-2:0], 1'b0};
          rem      <= rem_step;
          quot     <= quot_step;
          cnt      <= cnt + 5'd1;
          if (div_last) begin
            duty  <= {quot_step[CountW-1:1], (rem_step[6:0] < PctDefault)};
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp.valid         <= 1'b1;
            rsp.prescale_code <= code;
            rsp.scale_value   <= div_sel;
            rsp.period_count  <= quot_sel - CountW'(1);
            rsp.duty_count    <= duty;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // kept quotients are odd and the fallback is 2047, so the period is even
  assert property (@(posedge clk) disable iff (rst) rsp.valid |-> !rsp.period_count[0])
    else $error("odd period_count");

  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_DIV))
    else $error("request accepted but ratio division not started");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && div_last && d_idx == LastDivIdx) |=> (state == S_MUL))
    else $error("divisor scan did not end after divisor 32");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (divisor == FreqW'(d_idx) + FreqW'(1)))
    else $error("scan divisor out of step with divisor index");

endmodule
